// ----- hdl/b64d_pkg.sv -----
package b64d_pkg;

   localparam logic [7:0] PAD_CHAR    = 8'h3D;
   localparam int         QUEUE_DEPTH = 4;
   localparam int         QPTR_W      = $clog2(QUEUE_DEPTH);

   // one decoded quantum (or the reject marker) handed from front to back
   typedef struct packed {
      logic [23:0] quantum;     // bytes from bit 23 down
      logic [1:0]  byte_count;  // 1..3 bytes to send
      logic        final_job;   // last job of the message
      logic        bad;         // message rejected: one zero byte, flagged
   } job_type;

   // alphabet lookup: bit 6 = valid, bits 5:0 = sextet
   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      logic [7:0] t;
      t = 8'h00;
      if (c >= 8'h41 && c <= 8'h5A) begin
         t = c - 8'h41;
         return {1'b1, t[5:0]};
      end
      if (c >= 8'h61 && c <= 8'h7A) begin
         t = c - 8'h47;
         return {1'b1, t[5:0]};
      end
      if (c >= 8'h30 && c <= 8'h39) begin
         t = c + 8'h04;
         return {1'b1, t[5:0]};
      end
      if (c == 8'h2B) return {1'b1, 6'd62};
      if (c == 8'h2F) return {1'b1, 6'd63};
      return 7'd0;
   endfunction

endpackage

// ----- hdl/base64_strict_decoder_core.sv -----
// channel | dir | tdata             | tlast          | tuser
// req_    | in  | [7:0] symbol      | end_of_message | -
// rsp_    | out | [7:0] data_byte   | final_byte     | bad_encoding
//
// One character beat is taken per cycle; a quantum's bytes leave at one
// beat per cycle from a registered output, at most 3 data bytes per 4 characters;
// a rejected message gives one reject beat. With an idle back, the first byte of
// a quantum follows its fourth character's beat via queue write, back load, output reg.
// The front stalls only when the 4-entry job queue is full; the back stalls
// on rsp_tready. Synchronous active-high reset clears message state and queue.
module base64_strict_decoder_core
   import b64d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] symbol
   input  logic       req_tlast,   // end_of_message
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] data_byte
   output logic       rsp_tlast,   // final_byte
   output logic       rsp_tuser    // [0] bad_encoding
);

   logic    q_full, q_push, q_pop, q_valid;
   job_type push_job, head_job;

   // classify characters, track quantum position, pads and sticky error
   b64d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_symbol (req_tdata),
      .in_last   (req_tlast),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_job     (push_job)
   );

   // decouples character intake from byte output
   b64d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_job   (head_job)
   );

   // serialize each job into 1..3 byte beats (or one reject beat)
   b64d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_job     (head_job),
      .q_pop     (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata),
      .out_last  (rsp_tlast),
      .out_bad   (rsp_tuser)
   );

endmodule

// ----- hdl/b64d_front.sv -----
module b64d_front
   import b64d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_symbol,
   input  logic       in_last,
   input  logic       q_full,
   output logic       q_push,
   output job_type    q_job
);

   logic [23:0] acc_ff, acc_in;
   logic [1:0]  pos_ff, pos_in;
   logic [1:0]  pads_ff, pads_in;
   logic        err_ff, err_in;

   logic        accept, is_pad, completes, err_now;
   logic [6:0]  lut;
   logic [5:0]  v_eff;
   logic [1:0]  pads_upd;
   logic [23:0] acc_upd;

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;

   always_comb begin
      is_pad    = (in_symbol == PAD_CHAR);
      lut       = sextet_of(in_symbol);
      completes = (pos_ff == 2'd3);
      v_eff     = (!is_pad && lut[6]) ? lut[5:0] : 6'd0;
      pads_upd  = is_pad ? pads_ff + 2'd1 : pads_ff;
      acc_upd   = {acc_ff[17:0], v_eff};
      err_now   = err_ff
                | (is_pad && pos_ff < 2'd2)
                | (!is_pad && !lut[6])
                | (!is_pad && pads_ff != 2'd0)
                | (in_last && !completes)
                | (completes && !in_last && pads_upd != 2'd0);

      q_push             = accept && (in_last || (completes && !err_now));
      q_job.quantum      = acc_upd;
      q_job.byte_count   = (in_last && err_now) ? 2'd1 : 2'd3 - pads_upd;
      q_job.final_job    = in_last;
      q_job.bad          = in_last && err_now;

      acc_in  = acc_ff;
      pos_in  = pos_ff;
      pads_in = pads_ff;
      err_in  = err_ff;
      if (accept) begin
         if (in_last) begin
            acc_in  = '0;
            pos_in  = '0;
            pads_in = '0;
            err_in  = 1'b0;
         end else begin
            pos_in  = pos_ff + 2'd1;
            err_in  = err_now;
            acc_in  = completes ? 24'd0 : acc_upd;
            pads_in = completes ? 2'd0 : pads_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         pos_ff  <= '0;
         pads_ff <= '0;
         err_ff  <= 1'b0;
      end else begin
         acc_ff  <= acc_in;
         pos_ff  <= pos_in;
         pads_ff <= pads_in;
         err_ff  <= err_in;
      end
   end

endmodule

// ----- hdl/b64d_queue.sv -----
module b64d_queue
   import b64d_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   job_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]    cnt_ff, cnt_in;

   assign full       = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_job   = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

endmodule

// ----- hdl/b64d_back.sv -----
module b64d_back
   import b64d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  job_type    q_job,
   output logic       q_pop,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [7:0] out_data,
   output logic       out_last,
   output logic       out_bad
);

   logic    work_valid_ff, work_valid_in;
   job_type work_ff, work_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic    rsp_last_ff, rsp_last_in;
   logic    rsp_bad_ff, rsp_bad_in;

   logic    load, emit, last_byte;

   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_data_ff;
   assign out_last  = rsp_last_ff;
   assign out_bad   = rsp_bad_ff;

   always_comb begin
      load      = !rsp_valid_ff || out_ready;
      emit      = work_valid_ff && load;
      last_byte = (work_ff.byte_count == 2'd1);
      q_pop     = q_valid && (!work_valid_ff || (emit && last_byte));

      work_valid_in = work_valid_ff;
      work_in       = work_ff;
      if (emit) begin
         work_in.quantum    = {work_ff.quantum[15:0], 8'h00};
         work_in.byte_count = work_ff.byte_count - 2'd1;
         if (last_byte) work_valid_in = 1'b0;
      end
      if (q_pop) begin
         work_valid_in = 1'b1;
         work_in       = q_job;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_bad_in   = rsp_bad_ff;
      if (load) begin
         rsp_valid_in = emit;
         rsp_data_in  = work_ff.bad ? 8'h00 : work_ff.quantum[23:16];
         rsp_last_in  = work_ff.final_job && last_byte;
         rsp_bad_in   = work_ff.bad;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
   import b64d_pkg::*;

   // one encoded character waiting to go out on req_
   typedef struct {
      logic [7:0] symbol;
      logic       eom;
      logic       drain_first;   // hold this beat until every decoded byte is back
   } char_beat_type;

   // one decoded byte (or reject marker) due on rsp_
   typedef struct {
      logic [7:0] data;
      logic       final_byte;
      logic       bad;
   } byte_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] symbol
   logic       req_tlast = 1'b0;    // end_of_message
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] data_byte
   logic       rsp_tlast;           // final_byte
   logic       rsp_tuser;           // [0] bad_encoding

   char_beat_type encoded_chars[$];
   byte_beat_type decoded_bytes[$];
   byte_beat_type head;

   // decoder state as the block should hold it
   logic [23:0] acc_bits  = '0;
   logic [1:0]  slot      = '0;
   logic [1:0]  pad_count = '0;
   logic        reject    = 1'b0;

   int chars_taken  = 0;
   int msgs_taken   = 0;
   int bytes_seen   = 0;
   int rejects_seen = 0;
   int fail_count   = 0;
   int hold_left    = 0;
   logic hold_done  = 1'b0;
   logic calm;

   // no random idling on either side while this window of characters goes by
   assign calm = (chars_taken >= 130) && (chars_taken < 190);

   base64_strict_decoder_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // alphabet lookup: bit 6 = valid, bits 5:0 = sextet value
   function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
      if (c >= "A" && c <= "Z") return {1'b1, 6'(c - "A")};
      if (c >= "a" && c <= "z") return {1'b1, 6'(c - "a" + 26)};
      if (c >= "0" && c <= "9") return {1'b1, 6'(c - "0" + 52)};
      if (c == "+") return {1'b1, 6'd62};
      if (c == "/") return {1'b1, 6'd63};
      return 7'd0;
   endfunction

   function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
      if (v < 26) return 8'("A" + v);
      if (v < 52) return 8'("a" + v - 26);
      if (v < 62) return 8'("0" + v - 52);
      if (v == 62) return "+";
      return "/";
   endfunction

   function automatic logic [7:0] random_char();
      return sextet_to_char(6'($urandom_range(0, 63)));
   endfunction

   // advance the decoder state by one accepted character and queue its bytes
   task automatic decode_symbol(input logic [7:0] c, input logic eom);
      logic          completes;
      logic [6:0]    lookup;
      logic [5:0]    v;
      int            n;
      byte_beat_type b;
      completes = (slot == 2'd3);
      v = '0;
      if (c == PAD_CHAR) begin
         if (slot < 2'd2) reject = 1'b1;   // pad in the first half of a quantum
         pad_count = pad_count + 2'd1;
      end else begin
         lookup = char_to_sextet(c);
         if (!lookup[6]) reject = 1'b1;    // not in the alphabet
         else v = lookup[5:0];
         if (pad_count != 0) reject = 1'b1; // data after a pad
      end
      acc_bits = {acc_bits[17:0], v};
      if (eom && !completes) reject = 1'b1;                     // length not a multiple of 4
      if (completes && !eom && pad_count != 0) reject = 1'b1;   // padded quantum mid-message
      if (completes && !reject) begin
         n = 3 - int'(pad_count);
         for (int k = 0; k < n; k++) begin
            b.data       = acc_bits[23 - 8*k -: 8];
            b.final_byte = eom && (k == n - 1);
            b.bad        = 1'b0;
            decoded_bytes.push_back(b);
         end
      end
      if (eom) begin
         if (reject) begin
            b.data       = 8'h00;
            b.final_byte = 1'b1;
            b.bad        = 1'b1;
            decoded_bytes.push_back(b);
         end
         acc_bits  = '0;
         slot      = '0;
         pad_count = '0;
         reject    = 1'b0;
      end else begin
         slot = slot + 2'd1;
         if (completes) begin
            acc_bits  = '0;
            pad_count = '0;
         end
      end
   endtask

   task automatic add_char(input logic [7:0] c, input logic eom, input logic drain);
      char_beat_type it;
      it.symbol      = c;
      it.eom         = eom;
      it.drain_first = drain;
      encoded_chars.push_back(it);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_char(s[i], i == s.len() - 1, 1'b0);
   endtask

   // mostly well-formed messages with random content, the rest broken or noise
   task automatic add_random_message(input logic drain);
      logic [7:0] msg[$];
      int nq, pads, kind, pos, noise_len;
      nq = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 10) : $urandom_range(1, 3);
      for (int i = 0; i < nq * 4; i++) msg.push_back(random_char());
      pads = $urandom_range(0, 2);
      if (pads >= 1) msg[msg.size() - 1] = PAD_CHAR;
      if (pads == 2) msg[msg.size() - 2] = PAD_CHAR;
      kind = $urandom_range(0, 99);
      pos  = $urandom_range(0, msg.size() - 1);
      if (kind < 70) begin
         // well-formed
      end else if (kind < 78) begin
         msg[pos] = 8'($urandom_range(0, 255));
      end else if (kind < 84) begin
         msg[pos] = PAD_CHAR;
      end else if (kind < 88) begin
         void'(msg.pop_back());
         if (msg.size() == 0) msg.push_back(random_char());
      end else if (kind < 92) begin
         msg.push_back(random_char());
      end else if (kind < 96) begin
         // padded quantum that is not the last one
         msg[2] = ($urandom_range(0, 1) != 0) ? PAD_CHAR : msg[2];
         msg[3] = PAD_CHAR;
         if (nq == 1) for (int i = 0; i < 4; i++) msg.push_back(random_char());
      end else begin
         msg.delete();
         noise_len = $urandom_range(1, 9);
         for (int i = 0; i < noise_len; i++) msg.push_back(8'($urandom_range(0, 255)));
      end
      for (int i = 0; i < msg.size(); i++) add_char(msg[i], i == msg.size() - 1, drain && i == 0);
   endtask

   // driver: one beat per handshake, random gaps, drain pause on marked beats
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            decode_symbol(req_tdata, req_tlast);
            chars_taken <= chars_taken + 1;
            if (req_tlast) msgs_taken <= msgs_taken + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (encoded_chars.size() != 0
                && !(encoded_chars[0].drain_first && decoded_bytes.size() != 0)
                && (calm || $urandom_range(0, 99) >= 28)) begin
               req_tdata  <= encoded_chars[0].symbol;
               req_tlast  <= encoded_chars[0].eom;
               req_tvalid <= 1'b1;
               void'(encoded_chars.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver ready: random stalls plus one long hold-off so the job queue backs up
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
         hold_done  <= 1'b0;
      end else if (!hold_done && chars_taken >= 70) begin
         hold_done  <= 1'b1;
         hold_left  <= 400;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(0, 99) >= 28);
      end
   end

   // monitor: every rsp_ beat against the oldest predicted byte
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rsp_tuser) rejects_seen <= rejects_seen + 1;
         else bytes_seen <= bytes_seen + 1;
         if (decoded_bytes.size() == 0) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
               $display("unexpected beat: data=%h last=%b bad=%b", rsp_tdata, rsp_tlast, rsp_tuser);
         end else begin
            head = decoded_bytes.pop_front();
            if (rsp_tdata !== head.data || rsp_tlast !== head.final_byte
                || rsp_tuser !== head.bad) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10)
                  $display("mismatch: expected data=%h last=%b bad=%b, got data=%h last=%b bad=%b",
                           head.data, head.final_byte, head.bad, rsp_tdata, rsp_tlast, rsp_tuser);
            end
         end
      end
   end

   initial begin
      // directed: full quantum, two and one pads with nonzero leftover bits
      add_text("TWFu");
      add_text("TR==");
      add_text("TWF=");
      // lone pad: pad at position 0 and short length
      add_text("=");
      // data character after a pad
      add_text("AB=C");
      // padded quantum followed by more data
      add_text("AA==//8A");
      // bytes outside the alphabet, incl. the field extremes
      add_char(8'h00, 1'b0, 1'b0);
      add_char(8'h80, 1'b0, 1'b0);
      add_char(8'hFF, 1'b1, 1'b0);

      add_random_message(1'b1);
      while (encoded_chars.size() < 270)
         add_random_message(encoded_chars.size() >= 200 && encoded_chars.size() < 212);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (encoded_chars.size() != 0 || req_tvalid) @(posedge clock);
      while (decoded_bytes.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("tb_top: %0d characters in %0d messages decoded, %0d bytes and %0d rejects checked",
               chars_taken, msgs_taken, bytes_seen, rejects_seen);
      $display("tb_top: %0d mismatching beats", fail_count);
      if (fail_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/b64d_pkg.sv
hdl/b64d_front.sv
hdl/b64d_queue.sv
hdl/b64d_back.sv
hdl/base64_strict_decoder_core.sv
tb/tb_top.sv
